/* design/hent_pkg.sv */
// ----------------------------------------------------------------------------
// hent_pkg: shared types, widths and log tables for histogram_entropy
// Holds the request/result structs, the internal bin request and the fixed
// point natural log tables, built at elaboration from a Q32 atanh series.
// ----------------------------------------------------------------------------
package hent_pkg;

  localparam int COUNT_BITS     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int LOG_TABLE_BITS = 8;

  localparam int TAB_SIZE  = 1 << LOG_TABLE_BITS;
  localparam int TOT_W     = 48;
  localparam int SUM_W     = 64;
  localparam int OUT_W     = 21;
  // 48 * ln2 < 64, so six integer bits cover any log of the total
  localparam int LOG_W     = FRAC_BITS + 6;
  localparam int E_W       = $clog2(TOT_W);
  localparam int EXP_SIZE  = 1 << E_W;
  localparam int PROD_W    = COUNT_BITS + LOG_W;
  localparam int STEP_W    = $clog2(SUM_W);
  localparam int BQ_DEPTH  = 2;
  localparam int BQ_AW     = $clog2(BQ_DEPTH);

  typedef struct packed {
    logic [31:0] bin_hits;
    logic        last_bin;
  } in_req_t;

  typedef struct packed {
    logic [20:0] entropy_q16;
    logic        empty_flag;
  } result_t;

  // classified bin: count, top set bit and the mantissa bits below it
  typedef struct packed {
    logic [COUNT_BITS-1:0]     count;
    logic [E_W-1:0]            exp;
    logic [LOG_TABLE_BITS-1:0] mant;
    logic                      last;
  } bin_req_t;

  typedef logic [TAB_SIZE-1:0][LOG_W-1:0] mant_tab_t;
  typedef logic [EXP_SIZE-1:0][LOG_W-1:0] exp_tab_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2*atanh(num/den) in Q32, rounded half up to FRAC_BITS
  function automatic logic [63:0] atanh_log(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] pw;
    logic [63:0] acc;
    logic [63:0] k;
    y   = udiv64(num << 32, den);
    y2  = (y * y) >> 32;
    pw  = y;
    acc = y;
    k   = 64'd1;
    while (pw != 64'd0 && k < 64'd64) begin
      pw  = (pw * y2) >> 32;
      acc = acc + udiv64(pw, (k << 1) + 64'd1);
      k   = k + 64'd1;
    end
    acc = acc << 1;
    return (acc + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  endfunction

  function automatic mant_tab_t build_mant_tab();
    mant_tab_t   t;
    logic [63:0] v;
    for (int m = 0; m < TAB_SIZE; m++) begin
      v    = atanh_log(64'(m), (64'd1 << (LOG_TABLE_BITS + 1)) + 64'(m));
      t[m] = v[LOG_W-1:0];
    end
    return t;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] ln2;
    logic [63:0] v;
    ln2 = atanh_log(64'd1, 64'd3);
    for (int e = 0; e < EXP_SIZE; e++) begin
      v    = 64'(e) * ln2;
      t[e] = v[LOG_W-1:0];
    end
    return t;
  endfunction

  localparam mant_tab_t MANT_TAB = build_mant_tab();
  localparam exp_tab_t  EXP_TAB  = build_exp_tab();

  // L(v) = e*ln2 + ln(1 + m/2^LOG_TABLE_BITS)
  function automatic logic [LOG_W-1:0] fixed_log(input logic [E_W-1:0] e,
                                                 input logic [LOG_TABLE_BITS-1:0] m);
    return EXP_TAB[e] + MANT_TAB[m];
  endfunction

endpackage

/* design/hent_front.sv */
// ----------------------------------------------------------------------------
// hent_front: input stage
// Registers one request, finds the top set bit of the count, and hands the
// classified bin to the bin queue with its mantissa bits.
// ----------------------------------------------------------------------------
module hent_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  hent_pkg::in_req_t  in_data,
  output logic               bq_push,
  output hent_pkg::bin_req_t bq_data,
  input  logic               bq_full
);
  import hent_pkg::*;

  localparam logic [E_W-1:0] TOP_BIT = E_W'(COUNT_BITS - 1);

  logic                      hold_valid_r;
  logic                      hold_valid_nxt;
  logic [COUNT_BITS-1:0]     hold_cnt_r;
  logic [E_W-1:0]            hold_exp_r;
  logic                      hold_last_r;
  logic                      accept;
  logic [COUNT_BITS-1:0]     cnt_in;
  logic [E_W-1:0]            shamt;
  logic [COUNT_BITS+LOG_TABLE_BITS-1:0] norm;

  function automatic logic [E_W-1:0] msb_index(input logic [COUNT_BITS-1:0] v);
    logic [E_W-1:0] r;
    r = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (v[i]) r = E_W'(i);
    end
    return r;
  endfunction

  assign cnt_in  = in_data.bin_hits[COUNT_BITS-1:0];
  assign in_full = hold_valid_r && bq_full;
  assign accept  = in_push && !in_full;
  assign bq_push = hold_valid_r && !bq_full;

  // left-justify the count so the bits below the top one fall in place
  assign shamt = TOP_BIT - hold_exp_r;
  assign norm  = {hold_cnt_r, {LOG_TABLE_BITS{1'b0}}} << shamt;

  always_comb begin
    bq_data.count = hold_cnt_r;
    bq_data.exp   = hold_exp_r;
    bq_data.mant  = norm[COUNT_BITS+LOG_TABLE_BITS-2 -: LOG_TABLE_BITS];
    bq_data.last  = hold_last_r;
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (bq_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cnt_r  <= cnt_in;
      hold_exp_r  <= msb_index(cnt_in);
      hold_last_r <= in_data.last_bin;
    end
  end

endmodule

/* design/hent_fifo.sv */
// ----------------------------------------------------------------------------
// hent_fifo: bin queue
// Short queue of classified bins between the front and the back end.
// ----------------------------------------------------------------------------
module hent_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hent_pkg::bin_req_t wr_data,
  output logic               full,
  input  logic               pop,
  output hent_pkg::bin_req_t rd_data,
  output logic               empty
);
  import hent_pkg::*;

  bin_req_t         mem_r [BQ_DEPTH];
  logic [BQ_AW-1:0] wr_ptr_r;
  logic [BQ_AW-1:0] wr_ptr_nxt;
  logic [BQ_AW-1:0] rd_ptr_r;
  logic [BQ_AW-1:0] rd_ptr_nxt;
  logic [BQ_AW:0]   fill_r;
  logic [BQ_AW:0]   fill_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill_r == (BQ_AW+1)'(BQ_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == BQ_AW'(BQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == BQ_AW'(BQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/hent_back.sv */
// ----------------------------------------------------------------------------
// hent_back: accumulate and finish
// Looks up L(c), multiplies c*L(c) and accumulates N and S with saturation.
// On the last bin runs a bit-serial S/N divide next to a bit-serial
// normalize of N, then forms L(N) - S/N into the result register.
// ----------------------------------------------------------------------------
module hent_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bq_empty,
  input  hent_pkg::bin_req_t bq_head,
  output logic               bq_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output hent_pkg::result_t  out_data
);
  import hent_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_t;

  back_state_t            state_r;
  back_state_t            state_nxt;
  logic [TOT_W-1:0]       total_r;
  logic [TOT_W-1:0]       total_nxt;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic                   res_valid_r;
  logic                   res_valid_nxt;
  logic [STEP_W-1:0]      step_r;
  logic [STEP_W-1:0]      step_nxt;

  logic [COUNT_BITS-1:0]  cnt_r;
  logic [LOG_W-1:0]       log_r;
  logic                   last_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SUM_W-1:0]       quo_r;
  logic [TOT_W:0]         rem_r;
  logic [TOT_W-1:0]       norm_r;
  logic [E_W-1:0]         nexp_r;
  logic [LOG_W-1:0]       lnn_r;
  result_t                res_r;

  logic                   load;
  logic                   write_res;
  logic [SUM_W-1:0]       prod_sat;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_acc;
  logic [TOT_W:0]         tot_add;
  logic [TOT_W-1:0]       tot_acc;
  logic [TOT_W:0]         rem_sh;
  logic                   rem_ge;
  logic [LOG_W-1:0]       diff;
  logic [OUT_W-1:0]       entropy;
  result_t                res_nxt;

  // take the next bin from idle, or while accumulating a non-last one
  assign load = !bq_empty &&
                ((state_r == ST_IDLE) || ((state_r == ST_ACC) && !last_r));
  assign bq_pop    = load;
  assign write_res = (state_r == ST_OUT) && !res_valid_r;

  // saturating accumulators
  assign prod_sat = ((prod_r >> SUM_W) != '0) ? '1 : SUM_W'(prod_r);
  assign sum_add  = {1'b0, sum_r} + {1'b0, prod_sat};
  assign sum_acc  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign tot_add  = {1'b0, total_r} + (TOT_W+1)'(cnt_r);
  assign tot_acc  = tot_add[TOT_W] ? '1 : tot_add[TOT_W-1:0];

  // one restoring step; the dividend shifts out as the quotient shifts in
  assign rem_sh = {rem_r[TOT_W-1:0], quo_r[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, total_r});

  // L(N) - S/N, floored at zero and clamped to the output range
  assign diff    = (quo_r >= SUM_W'(lnn_r)) ? '0 : lnn_r - quo_r[LOG_W-1:0];
  assign entropy = ((diff >> OUT_W) != '0) ? '1 : OUT_W'(diff);

  always_comb begin
    if (total_r == '0) begin
      res_nxt.entropy_q16 = '0;
      res_nxt.empty_flag  = 1'b1;
    end else begin
      res_nxt.entropy_q16 = entropy;
      res_nxt.empty_flag  = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    step_nxt      = step_r;
    res_valid_nxt = res_valid_r;
    if (out_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (load) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        total_nxt = tot_acc;
        sum_nxt   = sum_acc;
        if (last_r) begin
          state_nxt = ST_DIV;
          step_nxt  = '0;
        end else if (load) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (write_res) begin
          res_valid_nxt = 1'b1;
          total_nxt     = '0;
          sum_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      sum_r       <= '0;
      step_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      step_r      <= step_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r  <= bq_head.count;
      log_r  <= fixed_log(bq_head.exp, bq_head.mant);
      last_r <= bq_head.last;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(cnt_r) * PROD_W'(log_r);
    end
    if ((state_r == ST_ACC) && last_r) begin
      quo_r  <= sum_acc;
      rem_r  <= '0;
      norm_r <= tot_acc;
      nexp_r <= E_W'(TOT_W - 1);
    end
    if (state_r == ST_DIV) begin
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sh - {1'b0, total_r} : rem_sh;
      if ((norm_r != '0) && !norm_r[TOT_W-1]) begin
        norm_r <= norm_r << 1;
        nexp_r <= nexp_r - 1'b1;
      end
      lnn_r <= fixed_log(nexp_r, norm_r[TOT_W-2 -: LOG_TABLE_BITS]);
    end
    if (write_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_empty = !res_valid_r;
  assign out_data  = res_r;

endmodule

/* design/histogram_entropy.sv */
// ----------------------------------------------------------------------------
// histogram_entropy: Shannon entropy in nats of a streamed histogram
// Bins: each is multiplied, then accumulated; the back end takes the next during accumulate.
// Finish: once its last bin is taken, the result waits on the 64-step bit-serial
// S/N divider; bins of the next histogram queue meanwhile.
// Reset: synchronous, active low; clears the accumulators, queue and result valid flag.
// The log tables are constants, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
//
// Data flow:
//   front : register the request, find the top set bit of the count
//   queue : two classified bins, lets the front keep taking requests while
//           the back end multiplies or divides
//   back  : L(c) from the log tables, c*L(c), saturating N and S sums;
//           on the last bin, S/N one quotient bit per cycle while N is
//           normalized one bit per cycle to get L(N); emit L(N) - S/N
//
// An all-zero histogram emits entropy 0 with empty_flag set.
module histogram_entropy (
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              in_push,
  output logic              in_full,
  input  hent_pkg::in_req_t in_data,
  // result side
  output logic              out_empty,
  input  logic              out_pop,
  output hent_pkg::result_t out_data
);
  import hent_pkg::*;

  // front to queue
  logic     fq_push;
  bin_req_t fq_data;
  logic     fq_full;
  // queue to back end
  logic     bq_pop;
  bin_req_t bq_head;
  logic     bq_empty;

  // classify each request and hold it until the queue has room
  hent_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .bq_push (fq_push),
    .bq_data (fq_data),
    .bq_full (fq_full)
  );

  // decouple the front from the back end
  hent_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_data),
    .full    (fq_full),
    .pop     (bq_pop),
    .rd_data (bq_head),
    .empty   (bq_empty)
  );

  // accumulate, divide and drive the result register
  hent_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bq_empty  (bq_empty),
    .bq_head   (bq_head),
    .bq_pop    (bq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* tb/histogram_entropy_tb.sv */
// ----------------------------------------------------------------------------
// histogram_entropy_tb: self-checking bench for the histogram entropy block
// Streams histograms, bin by bin, into the request queue and checks every
// entropy result against a bit-exact log math predictor or a typed row's value.
// A directed table comes first, then random histograms with random idling,
// a back-pressure phase and one long histogram of full-scale counts.
// ----------------------------------------------------------------------------
module histogram_entropy_tb;
  import hent_pkg::*;

  localparam longint unsigned TOTAL_CAP  = (64'd1 << TOT_W) - 64'd1;
  localparam longint unsigned CLOGC_CAP  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned ENT_CAP    = (64'd1 << OUT_W) - 64'd1;
  localparam int              RAND_BINS  = 1730;
  localparam int              CALM_BINS  = 320;
  localparam int              HOLD_CYC   = 400;
  localparam int              LONG_BINS  = 64;
  localparam int              TAIL_CYC   = 100;

  // one row of directed stimulus; want is used only when typed is set
  typedef struct packed {
    in_req_t req;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty histogram right after reset: flagged, entropy forced to zero
    '{'{32'd0, 1'b1}, 1'b1, '{21'd0, 1'b1}},
    // a lone bin of one has zero entropy, and L(1) is zero
    '{'{32'd1, 1'b1}, 1'b1, '{21'd0, 1'b0}},
    // a lone bin at the top of the count range: still zero entropy
    '{'{32'hFFFF_FFFF, 1'b1}, 1'b1, '{21'd0, 1'b0}},
    // two equal bins: ln 2 in Q16
    '{'{32'd1, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd1, 1'b1}, 1'b1, '{21'd45426, 1'b0}},
    // all bins zero: same as empty
    '{'{32'd0, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd0, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd0, 1'b1}, 1'b1, '{21'd0, 1'b1}},
    // zero bins around one nonzero bin add nothing
    '{'{32'd0, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd5, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd0, 1'b1}, 1'b1, '{21'd0, 1'b0}},
    // four equal bins: 2 ln 2
    '{'{32'd1, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd1, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd1, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd1, 1'b1}, 1'b1, '{21'd90852, 1'b0}},
    // mantissa table edges and power-of-two steps
    '{'{32'd255, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd256, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd511, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'd512, 1'b1}, 1'b0, '{21'd0, 1'b0}},
    // extremes of the count field mixed in one histogram
    '{'{32'hFFFF_FFFF, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'h8000_0000, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'h0000_0001, 1'b1}, 1'b0, '{21'd0, 1'b0}},
    // alternating bit patterns
    '{'{32'h5555_5555, 1'b0}, 1'b0, '{21'd0, 1'b0}},
    '{'{32'hAAAA_AAAA, 1'b1}, 1'b0, '{21'd0, 1'b0}}
  };

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_push   = 1'b0;
  logic    in_full;
  in_req_t in_data   = '0;
  logic    out_empty;
  logic    out_pop   = 1'b0;
  result_t out_data;

  // stimulus toggles hold_tog to ask the receiver for one long hold-off
  logic    hold_tog  = 1'b0;
  // calm: no random idling on either side
  bit      calm      = 1'b0;

  int unsigned err_count;
  int unsigned bins_sent;
  int unsigned results_seen;

  // predictor state: log tables and the two running sums
  longint unsigned ln_mant [TAB_SIZE];
  longint unsigned ln_two;
  longint unsigned hist_total;
  longint unsigned hist_clogc;

  // entropy results still owed by the block, oldest first
  result_t entropy_due [$];

  histogram_entropy dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20000000;
    $display("histogram_entropy_tb: FAIL");
    $finish;
  end

  task automatic report_err(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // 2*atanh(num/den) with a Q32 series, rounded half up to FRAC_BITS
  function automatic longint unsigned series_ln(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned y;
    longint unsigned ysq;
    longint unsigned term;
    longint unsigned acc;
    y    = (num << 32) / den;
    ysq  = (y * y) >> 32;
    term = y;
    acc  = y;
    for (longint unsigned k = 1; term != 0 && k < 64; k++) begin
      term = (term * ysq) >> 32;
      acc  = acc + term / (2 * k + 1);
    end
    acc = acc * 2;
    return (acc + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  endfunction

  function automatic void build_log_tables();
    for (int m = 0; m < TAB_SIZE; m++) begin
      ln_mant[m] = series_ln(longint'(m), (64'd1 << (LOG_TABLE_BITS + 1)) + longint'(m));
    end
    ln_two = series_ln(64'd1, 64'd3);
  endfunction

  // table log: top bit index times ln 2, plus ln of the mantissa below it
  function automatic longint unsigned nat_log(input longint unsigned v);
    int unsigned     top;
    longint unsigned m;
    top = 0;
    if (v == 0) begin
      return 0;
    end
    for (int b = 1; b < 64; b++) begin
      if (v[b]) top = b;
    end
    if (top >= LOG_TABLE_BITS) m = v >> (top - LOG_TABLE_BITS);
    else                       m = v << (LOG_TABLE_BITS - top);
    m = m & (TAB_SIZE - 1);
    return longint'(top) * ln_two + ln_mant[m];
  endfunction

  // fold one bin into the sums; on the last bin produce the entropy
  function automatic bit accumulate_bin(input in_req_t r, output result_t res);
    longint unsigned c;
    longint unsigned lg;
    longint unsigned prod;
    longint unsigned ln_n;
    longint unsigned quo;
    longint unsigned h;
    res = '0;
    c   = longint'(r.bin_hits) & ((64'd1 << COUNT_BITS) - 64'd1);
    if (c != 0) begin
      lg = nat_log(c);
      hist_total = hist_total + c;
      if (hist_total > TOTAL_CAP) hist_total = TOTAL_CAP;
      if (lg != 0 && c > CLOGC_CAP / lg) prod = CLOGC_CAP;
      else                               prod = c * lg;
      if (hist_clogc > CLOGC_CAP - prod) hist_clogc = CLOGC_CAP;
      else                               hist_clogc = hist_clogc + prod;
    end
    if (!r.last_bin) begin
      return 1'b0;
    end
    if (hist_total == 0) begin
      res.entropy_q16 = '0;
      res.empty_flag  = 1'b1;
    end else begin
      ln_n = nat_log(hist_total);
      quo  = hist_clogc / hist_total;
      // a mean log at or above L(N) clamps to zero entropy
      h    = (quo >= ln_n) ? 64'd0 : ln_n - quo;
      if (h > ENT_CAP) h = ENT_CAP;
      res.entropy_q16 = h[OUT_W-1:0];
      res.empty_flag  = 1'b0;
    end
    hist_total = 0;
    hist_clogc = 0;
    return 1'b1;
  endfunction

  // offer one bin request, hold it until the queue takes it, then predict
  task automatic push_req(input in_req_t r, input bit typed, input result_t want);
    result_t res;
    while (!calm && $urandom_range(99) < 33) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_full);
    bins_sent++;
    if (accumulate_bin(r, res)) begin
      entropy_due.push_back(typed ? want : res);
    end
  endtask

  // drop push and hold the sender until every owed result has come back
  task automatic wait_all_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (entropy_due.size() != 0) @(posedge clk);
  endtask

  // mostly small counts, with every bit length up to the full field
  function automatic logic [31:0] rand_count();
    int unsigned w;
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'($urandom_range(3));
      default: begin
        w = $urandom_range(32, 1);
        return 32'($urandom()) >> (32 - w);
      end
    endcase
  endfunction

  // one histogram: flat, random, or one heavy bin among light ones
  task automatic send_histogram(input int unsigned nbins);
    int unsigned shape;
    logic [31:0] flat;
    in_req_t     r;
    shape = $urandom_range(3);
    flat  = rand_count();
    for (int unsigned i = 0; i < nbins; i++) begin
      case (shape)
        0:       r.bin_hits = flat;
        1:       r.bin_hits = (i == 0) ? 32'($urandom()) : 32'($urandom_range(15));
        default: r.bin_hits = rand_count();
      endcase
      r.last_bin = (i == nbins - 1);
      push_req(r, 1'b0, '0);
    end
  endtask

  function automatic int unsigned rand_hist_size();
    if ($urandom_range(9) == 0) return $urandom_range(48, 13);
    return $urandom_range(12, 1);
  endfunction

  // receiver: check each popped result, idle at random, and honor one
  // long hold-off that the stimulus asks for by toggling hold_tog
  initial begin : receiver
    logic        hold_seen;
    int unsigned hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        results_seen++;
        if (entropy_due.size() == 0) begin
          report_err($sformatf("result %0d with nothing owed: entropy=%0d empty=%0b",
                               results_seen, out_data.entropy_q16, out_data.empty_flag));
        end else begin
          if (out_data.entropy_q16 !== entropy_due[0].entropy_q16) begin
            report_err($sformatf("result %0d entropy_q16: got %0d want %0d", results_seen,
                                 out_data.entropy_q16, entropy_due[0].entropy_q16));
          end
          if (out_data.empty_flag !== entropy_due[0].empty_flag) begin
            report_err($sformatf("result %0d empty_flag: got %0b want %0b", results_seen,
                                 out_data.empty_flag, entropy_due[0].empty_flag));
          end
          void'(entropy_due.pop_front());
        end
      end
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = HOLD_CYC;
      end
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin : stimulus
    in_req_t r;
    err_count    = 0;
    bins_sent    = 0;
    results_seen = 0;
    hist_total   = 0;
    hist_clogc   = 0;
    build_log_tables();

    // hold reset low, once, then release it
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      push_req(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    wait_all_results();

    // random histograms, first a stretch with no idling on either side
    calm = 1'b1;
    while (bins_sent < CALM_BINS) send_histogram(rand_hist_size());
    calm = 1'b0;
    wait_all_results();

    // back-pressure: receiver holds off while single-bin histograms keep
    // coming, so the block fills and raises full; then drain completely
    hold_tog <= ~hold_tog;
    calm = 1'b1;
    for (int i = 0; i < 60; i++) begin
      r.bin_hits = rand_count();
      r.last_bin = 1'b1;
      push_req(r, 1'b0, '0);
    end
    calm = 1'b0;
    wait_all_results();

    // bulk of the random histograms with random idling
    while (bins_sent < RAND_BINS) send_histogram(rand_hist_size());
    wait_all_results();

    // one long histogram of full-scale bins drives N and S high
    r.bin_hits = 32'hFFFF_FFFF;
    for (int i = 0; i < LONG_BINS; i++) begin
      r.last_bin = (i == LONG_BINS - 1);
      push_req(r, 1'b0, '0);
    end
    wait_all_results();

    // allow for a late extra result, then judge
    repeat (TAIL_CYC) @(posedge clk);
    if (entropy_due.size() != 0) begin
      report_err($sformatf("%0d results never came", entropy_due.size()));
    end
    if (err_count == 0) begin
      $display("histogram_entropy_tb: PASS");
    end else begin
      $display("histogram_entropy_tb: FAIL");
    end
    $finish;
  end

endmodule
